// ===== rtl/pstsum_pkg.sv =====
// ----------------------------------------------------------------------------
// pstsum_pkg
// Shared codes and controller/datapath interface types of the versioned
// range-sum tree.
// ----------------------------------------------------------------------------
package pstsum_pkg;

  localparam int ACT_W  = 2;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 32;
  localparam int VER_W  = 10;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 11;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BUILD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_VERSION  = 2'd2;
  localparam logic [STAT_W-1:0] ST_POSITION = 2'd3;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic clear;
    logic accept;
    logic check;
    logic b_step;
    logic b_leaf;
    logic u_cnt;
    logic u_rd;
    logic u_wr;
    logic q_root;
    logic q_pop;
    logic q_node;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic             go;
    logic [ACT_W-1:0] act;
    logic             top_leaf;
    logic             top_ph2;
    logic             sp_one;
    logic             cnt_done;
    logic             u_full;
    logic             at_leaf;
    logic             sp_zero;
    logic             top_skip;
    logic             out_free;
  } stat_t;

endpackage

// ===== rtl/pstsum_ram.sv =====
// ----------------------------------------------------------------------------
// pstsum_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pstsum_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pstsum_ctrl.sv =====
// ----------------------------------------------------------------------------
// pstsum_ctrl
// Sequencer: clearing pass, item check, build walk, update path copy,
// query walk and result hand-off.
// ----------------------------------------------------------------------------
module pstsum_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  pstsum_pkg::stat_t  st,
  output logic               in_stall,
  output pstsum_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_CHECK  = 12'b000000000100,
    S_B_STEP = 12'b000000001000,
    S_B_LEAF = 12'b000000010000,
    S_U_CNT  = 12'b000000100000,
    S_U_RD   = 12'b000001000000,
    S_U_WR   = 12'b000010000000,
    S_Q_ROOT = 12'b000100000000,
    S_Q_POP  = 12'b001000000000,
    S_Q_NODE = 12'b010000000000,
    S_FINISH = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (st.clr_done) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (!st.go) begin
          state_next = S_FINISH;
        end else begin
          unique case (st.act)
            pstsum_pkg::ACT_BUILD:  state_next = S_B_STEP;
            pstsum_pkg::ACT_UPDATE: state_next = S_U_CNT;
            pstsum_pkg::ACT_QUERY:  state_next = S_Q_ROOT;
            default:                state_next = S_FINISH;
          endcase
        end
      end
      S_B_STEP: begin
        if (st.top_leaf) state_next = S_B_LEAF;
        else if (st.top_ph2 && st.sp_one) state_next = S_FINISH;
      end
      S_B_LEAF: state_next = st.sp_one ? S_FINISH : S_B_STEP;
      S_U_CNT: begin
        if (st.cnt_done) state_next = st.u_full ? S_FINISH : S_U_RD;
      end
      S_U_RD:   state_next = S_U_WR;
      S_U_WR:   if (st.at_leaf) state_next = S_FINISH; else state_next = S_U_RD;
      S_Q_ROOT: state_next = S_Q_POP;
      S_Q_POP: begin
        if (st.sp_zero) state_next = S_FINISH;
        else if (!st.top_skip) state_next = S_Q_NODE;
      end
      S_Q_NODE: state_next = S_Q_POP;
      S_FINISH: if (st.out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  assign in_stall   = (state != S_IDLE);
  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.accept = (state == S_IDLE) && in_valid;
  assign cmd.check  = (state == S_CHECK);
  assign cmd.b_step = (state == S_B_STEP);
  assign cmd.b_leaf = (state == S_B_LEAF);
  assign cmd.u_cnt  = (state == S_U_CNT);
  assign cmd.u_rd   = (state == S_U_RD);
  assign cmd.u_wr   = (state == S_U_WR);
  assign cmd.q_root = (state == S_Q_ROOT);
  assign cmd.q_pop  = (state == S_Q_POP);
  assign cmd.q_node = (state == S_Q_NODE);
  assign cmd.finish = (state == S_FINISH) && st.out_free;

endmodule

// ===== rtl/pstsum_dp.sv =====
// ----------------------------------------------------------------------------
// pstsum_dp
// Datapath: node pool, root table, staging store, walk stack, item and
// result registers.
// ----------------------------------------------------------------------------
module pstsum_dp #(
  parameter int MAX_LEAVES   = 1024,
  parameter int MAX_VERSIONS = 1024,
  parameter int POOL_NODES   = 16384
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pstsum_pkg::cmd_t                    cmd,
  output pstsum_pkg::stat_t                   st,
  input  logic [pstsum_pkg::ACT_W-1:0]        action,
  input  logic [pstsum_pkg::POS_W-1:0]        position,
  input  logic signed [pstsum_pkg::VAL_W-1:0] value,
  input  logic [pstsum_pkg::POS_W-1:0]        left_bound,
  input  logic [pstsum_pkg::POS_W-1:0]        right_bound,
  input  logic [pstsum_pkg::VER_W-1:0]        version,
  input  logic                                cfg_valid,
  input  logic [pstsum_pkg::CFG_W-1:0]        cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pstsum_pkg::VAL_W-1:0] sum,
  output logic [pstsum_pkg::VER_W-1:0]        new_version,
  output logic [pstsum_pkg::STAT_W-1:0]       status
);

  localparam int NW   = $clog2(MAX_LEAVES + 1);
  localparam int CW   = (NW > pstsum_pkg::POS_W) ? NW : pstsum_pkg::POS_W;
  localparam int LIW  = $clog2(MAX_LEAVES);
  localparam int VIW  = $clog2(MAX_VERSIONS);
  localparam int VCW  = $clog2(MAX_VERSIONS + 1);
  localparam int PW   = $clog2(POOL_NODES);
  localparam int FW   = $clog2(POOL_NODES + 1);
  localparam int SD   = 2 * LIW + 4;
  localparam int SIW  = $clog2(SD);
  localparam int SPW  = $clog2(SD + 1);
  localparam int NDW  = 2 * PW + 32;
  localparam int CNTW = $clog2(CW + 2);

  localparam logic [1:0] PH_NEW   = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;

  // item registers
  logic [pstsum_pkg::ACT_W-1:0]  a_act;
  logic [CW-1:0]                 a_pos, a_ql, a_qr;
  logic [31:0]                   a_val;
  logic [pstsum_pkg::VER_W-1:0]  a_ver;

  logic [pstsum_pkg::CFG_W-1:0]  size_cfg;
  logic [CW-1:0]                 ts;
  logic [VCW-1:0]                vc;
  logic [FW-1:0]                 free;
  logic [LIW-1:0]                clr_cnt;

  logic [CW-1:0]   stk_lo  [SD];
  logic [CW-1:0]   stk_hi  [SD];
  logic [1:0]      stk_ph  [SD];
  logic [PW-1:0]   stk_idx [SD];
  logic [31:0]     stk_sum [SD];
  logic [SPW-1:0]  sp;

  logic [PW-1:0]   ret_idx;
  logic [31:0]     ret_sum;
  logic [CW-1:0]   lo, hi;
  logic [PW-1:0]   cur, base;
  logic [CNTW-1:0] cnt;
  logic [31:0]     acc;
  logic [1:0]      stat_r;

  logic [NDW-1:0]  pool_rd, pool_wd;
  logic [PW-1:0]   root_rd, root_wd;
  logic [31:0]     stg_rd, stg_wd;
  logic            pool_we, pool_re, root_we, root_re, stg_we, stg_re;
  logic [PW-1:0]   pool_ra;
  logic [VIW-1:0]  root_wa, root_ra;
  logic [LIW-1:0]  stg_wa, stg_ra;

  logic [SIW-1:0]  top, sp_i, sp_i1;
  logic [CW-1:0]   t_lo, t_hi, t_mid, u_mid, n_use;
  logic [CW:0]     t_two, u_two;
  logic [PW-1:0]   p_l, p_r, free_i, free_p1;
  logic [31:0]     p_s, newsum;
  logic [1:0]      chk_err;
  logic            chk_go, top_leaf, top_ph2, top_skip, covered, u_full, sp_one, sp_zero;

  assign top     = SIW'(sp - SPW'(1));
  assign sp_i    = sp[SIW-1:0];
  assign sp_i1   = SIW'(sp + SPW'(1));
  assign t_lo    = stk_lo[top];
  assign t_hi    = stk_hi[top];
  assign t_two   = {1'b0, t_lo} + {1'b0, t_hi};
  assign t_mid   = t_two[CW:1];
  assign u_two   = {1'b0, lo} + {1'b0, hi};
  assign u_mid   = u_two[CW:1];
  assign p_l     = pool_rd[NDW-1 -: PW];
  assign p_r     = pool_rd[32 +: PW];
  assign p_s     = pool_rd[31:0];
  assign newsum  = p_s + a_val;
  assign free_i  = free[PW-1:0];
  assign free_p1 = PW'(free + FW'(1));
  assign sp_one  = (sp == SPW'(1));
  assign sp_zero = (sp == '0);

  assign top_leaf = (stk_ph[top] == PH_NEW) && (t_lo == t_hi);
  assign top_ph2  = (stk_ph[top] == PH_RIGHT);
  assign top_skip = (t_hi < a_ql) || (a_qr < t_lo);
  assign covered  = (a_ql <= lo) && (hi <= a_qr);
  assign u_full   = (33'(free) + 33'(cnt)) > 33'(POOL_NODES);

  // a register of zero means one leaf, anything above the limit means the limit
  always_comb begin
    if (size_cfg == '0) begin
      n_use = CW'(1);
    end else if (CW'(size_cfg) > CW'(MAX_LEAVES)) begin
      n_use = CW'(MAX_LEAVES);
    end else begin
      n_use = CW'(size_cfg);
    end
  end

  always_comb begin
    chk_err = pstsum_pkg::ST_OK;
    chk_go  = 1'b0;
    unique case (a_act)
      pstsum_pkg::ACT_LOAD: begin
        if (a_pos == '0 || a_pos > n_use) chk_err = pstsum_pkg::ST_POSITION;
      end
      pstsum_pkg::ACT_BUILD: begin
        if ((33'(n_use) << 1) - 33'd1 > 33'(POOL_NODES)) chk_err = pstsum_pkg::ST_FULL;
        else chk_go = 1'b1;
      end
      pstsum_pkg::ACT_UPDATE: begin
        if (vc == '0) chk_err = pstsum_pkg::ST_VERSION;
        else if (a_pos == '0 || a_pos > ts) chk_err = pstsum_pkg::ST_POSITION;
        else if (33'(vc) >= 33'(MAX_VERSIONS)) chk_err = pstsum_pkg::ST_FULL;
        else chk_go = 1'b1;
      end
      default: begin
        if (33'(a_ver) >= 33'(vc)) chk_err = pstsum_pkg::ST_VERSION;
        else if (a_ql == '0 || a_ql > ts || a_qr == '0 || a_qr > ts)
          chk_err = pstsum_pkg::ST_POSITION;
        else chk_go = (a_ql <= a_qr);
      end
    endcase
  end

  // memory ports
  assign pool_we = cmd.b_leaf || (cmd.b_step && top_ph2) || cmd.u_wr;
  always_comb begin
    if (cmd.b_leaf) begin
      pool_wd = {{(2 * PW){1'b0}}, stg_rd};
    end else if (cmd.b_step) begin
      pool_wd = {stk_idx[top], ret_idx, stk_sum[top] + ret_sum};
    end else if (lo == hi) begin
      pool_wd = {{(2 * PW){1'b0}}, newsum};
    end else if (a_pos <= u_mid) begin
      pool_wd = {free_p1, p_r, newsum};
    end else begin
      pool_wd = {p_l, free_p1, newsum};
    end
  end
  assign pool_re = cmd.u_rd || (cmd.q_pop && !sp_zero && !top_skip);
  assign pool_ra = cmd.u_rd ? cur : stk_idx[top];

  assign root_we = ((cmd.b_step && top_ph2) || cmd.b_leaf) && sp_one
                   || (cmd.u_wr && lo == hi);
  assign root_wa = cmd.u_wr ? VIW'(vc) : '0;
  assign root_wd = cmd.u_wr ? base : free_i;
  assign root_re = cmd.check && chk_go
                   && (a_act == pstsum_pkg::ACT_UPDATE || a_act == pstsum_pkg::ACT_QUERY);
  assign root_ra = (a_act == pstsum_pkg::ACT_UPDATE) ? VIW'(vc - VCW'(1)) : VIW'(a_ver);

  assign stg_we = cmd.clear || (cmd.check && a_act == pstsum_pkg::ACT_LOAD
                                && chk_err == pstsum_pkg::ST_OK);
  assign stg_wa = cmd.clear ? clr_cnt : LIW'(a_pos - CW'(1));
  assign stg_wd = cmd.clear ? '0 : a_val;
  assign stg_re = cmd.b_step && top_leaf;
  assign stg_ra = LIW'(t_lo - CW'(1));

  pstsum_ram #(.WIDTH(NDW), .DEPTH(POOL_NODES)) u_pool (
    .clk(clk), .we(pool_we), .waddr(free_i), .wdata(pool_wd),
    .re(pool_re), .raddr(pool_ra), .rdata(pool_rd)
  );

  pstsum_ram #(.WIDTH(PW), .DEPTH(MAX_VERSIONS)) u_root (
    .clk(clk), .we(root_we), .waddr(root_wa), .wdata(root_wd),
    .re(root_re), .raddr(root_ra), .rdata(root_rd)
  );

  pstsum_ram #(.WIDTH(32), .DEPTH(MAX_LEAVES)) u_stage (
    .clk(clk), .we(stg_we), .waddr(stg_wa), .wdata(stg_wd),
    .re(stg_re), .raddr(stg_ra), .rdata(stg_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg  <= pstsum_pkg::SIZE_RESET;
      ts        <= '0;
      vc        <= '0;
      free      <= '0;
      sp        <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) size_cfg <= cfg_data;
      if (cmd.clear) clr_cnt <= clr_cnt + LIW'(1);

      if (cmd.accept) begin
        a_act <= action;
        a_pos <= CW'(position);
        a_val <= value;
        a_ql  <= CW'(left_bound);
        a_qr  <= CW'(right_bound);
        a_ver <= version;
      end

      if (cmd.check) begin
        stat_r <= chk_err;
        acc    <= '0;
        if (chk_go && a_act == pstsum_pkg::ACT_BUILD) begin
          free      <= '0;
          ts        <= n_use;
          sp        <= SPW'(1);
          stk_lo[0] <= CW'(1);
          stk_hi[0] <= n_use;
          stk_ph[0] <= PH_NEW;
        end
        if (chk_go && a_act == pstsum_pkg::ACT_UPDATE) begin
          lo  <= CW'(1);
          hi  <= ts;
          cnt <= CNTW'(1);
        end
      end

      // post-order build: descend left, then right, then emit the parent
      if (cmd.b_step && !top_leaf) begin
        if (stk_ph[top] == PH_NEW) begin
          stk_ph[top]  <= PH_LEFT;
          stk_lo[sp_i] <= t_lo;
          stk_hi[sp_i] <= t_mid;
          stk_ph[sp_i] <= PH_NEW;
          sp           <= sp + SPW'(1);
        end else if (stk_ph[top] == PH_LEFT) begin
          stk_idx[top] <= ret_idx;
          stk_sum[top] <= ret_sum;
          stk_ph[top]  <= PH_RIGHT;
          stk_lo[sp_i] <= t_mid + CW'(1);
          stk_hi[sp_i] <= t_hi;
          stk_ph[sp_i] <= PH_NEW;
          sp           <= sp + SPW'(1);
        end else begin
          ret_idx <= free_i;
          ret_sum <= stk_sum[top] + ret_sum;
          free    <= free + FW'(1);
          sp      <= sp - SPW'(1);
          if (sp_one) vc <= VCW'(1);
        end
      end

      if (cmd.b_leaf) begin
        ret_idx <= free_i;
        ret_sum <= stg_rd;
        free    <= free + FW'(1);
        sp      <= sp - SPW'(1);
        if (sp_one) vc <= VCW'(1);
      end

      // count the path length before any node is written
      if (cmd.u_cnt) begin
        if (lo < hi) begin
          if (a_pos <= u_mid) hi <= u_mid;
          else lo <= u_mid + CW'(1);
          cnt <= cnt + CNTW'(1);
        end else if (u_full) begin
          stat_r <= pstsum_pkg::ST_FULL;
        end else begin
          lo   <= CW'(1);
          hi   <= ts;
          cur  <= root_rd;
          base <= free_i;
        end
      end

      if (cmd.u_wr) begin
        free <= free + FW'(1);
        if (lo == hi) begin
          vc <= vc + VCW'(1);
        end else if (a_pos <= u_mid) begin
          hi  <= u_mid;
          cur <= p_l;
        end else begin
          lo  <= u_mid + CW'(1);
          cur <= p_r;
        end
      end

      if (cmd.q_root) begin
        stk_idx[0] <= root_rd;
        stk_lo[0]  <= CW'(1);
        stk_hi[0]  <= ts;
        sp         <= SPW'(1);
      end

      if (cmd.q_pop && !sp_zero) begin
        sp <= sp - SPW'(1);
        lo <= t_lo;
        hi <= t_hi;
      end

      // partial overlap: push right then left so left pops first
      if (cmd.q_node) begin
        if (covered) begin
          acc <= acc + p_s;
        end else begin
          stk_idx[sp_i]  <= p_r;
          stk_lo[sp_i]   <= u_mid + CW'(1);
          stk_hi[sp_i]   <= hi;
          stk_idx[sp_i1] <= p_l;
          stk_lo[sp_i1]  <= lo;
          stk_hi[sp_i1]  <= u_mid;
          sp             <= sp + SPW'(2);
        end
      end

      if (cmd.finish) begin
        out_valid   <= 1'b1;
        sum         <= acc;
        status      <= stat_r;
        new_version <= (vc == '0) ? '0 : pstsum_pkg::VER_W'(vc - VCW'(1));
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.clr_done = (clr_cnt == LIW'(MAX_LEAVES - 1));
  assign st.go       = chk_go;
  assign st.act      = a_act;
  assign st.top_leaf = top_leaf;
  assign st.top_ph2  = top_ph2;
  assign st.sp_one   = sp_one;
  assign st.cnt_done = !(lo < hi);
  assign st.u_full   = u_full;
  assign st.at_leaf  = (lo == hi);
  assign st.sp_zero  = sp_zero;
  assign st.top_skip = top_skip;
  assign st.out_free = !out_valid || !out_stall;

`ifndef NO_ASSERTIONS
  a_stack_bound: assert property (@(posedge clk) disable iff (rst) sp <= SPW'(SD))
    else $error("walk stack overflow");
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
      33'(free) <= 33'(POOL_NODES))
    else $error("node pool overrun");
  a_version_bound: assert property (@(posedge clk) disable iff (rst)
      33'(vc) <= 33'(MAX_VERSIONS))
    else $error("version count overrun");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
      cmd.finish |-> (!out_valid || !out_stall))
    else $error("result written over a pending transfer");
`endif

endmodule

// ===== rtl/persistent_segment_tree_sum_unit.sv =====
// ----------------------------------------------------------------------------
// persistent_segment_tree_sum_unit
// Versioned range-sum tree with bounded node pool, one result per item.
// ----------------------------------------------------------------------------
// One item is worked at a time and each gives one result. After reset a
// clearing pass zeroes the staging store, one entry a cycle, before the
// first item is taken. Per item: load writes the staging store at the check
// step; build takes three steps per inner node and two per leaf, all
// through the single node-pool write port; update makes a length count,
// then one pool read and one write per level of the tree; query pops the
// walk stack, reading the pool for each entry that overlaps the range and
// skipping the others. Update and query share the node pool's single read
// port. A finished result waits in an output register while the next
// item is taken.
module persistent_segment_tree_sum_unit #(
  parameter int MAX_LEAVES   = 1024,
  parameter int MAX_VERSIONS = 1024,
  parameter int POOL_NODES   = 16384
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pstsum_pkg::ACT_W-1:0]        action,
  input  logic [pstsum_pkg::POS_W-1:0]        position,
  input  logic signed [pstsum_pkg::VAL_W-1:0] value,
  input  logic [pstsum_pkg::POS_W-1:0]        left_bound,
  input  logic [pstsum_pkg::POS_W-1:0]        right_bound,
  input  logic [pstsum_pkg::VER_W-1:0]        version,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pstsum_pkg::VAL_W-1:0] sum,
  output logic [pstsum_pkg::VER_W-1:0]        new_version,
  output logic [pstsum_pkg::STAT_W-1:0]       status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pstsum_pkg::CFG_W-1:0]        cfg_data
);

  pstsum_pkg::cmd_t  cmd;
  pstsum_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  pstsum_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .st(st),
    .in_stall(in_stall), .cmd(cmd)
  );

  pstsum_dp #(
    .MAX_LEAVES(MAX_LEAVES), .MAX_VERSIONS(MAX_VERSIONS), .POOL_NODES(POOL_NODES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .action(action), .position(position), .value(value),
    .left_bound(left_bound), .right_bound(right_bound), .version(version),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .sum(sum), .new_version(new_version), .status(status)
  );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Versioned range-sum tree unit testbench
// Drives load, build, update and query items through the valid/stall
// channels with random idling on both sides, writes the leaf-count register
// between phases, and checks every result against an in-bench tree model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic [pstsum_pkg::ACT_W-1:0]  action;
  logic [pstsum_pkg::POS_W-1:0]  position;
  logic [pstsum_pkg::VAL_W-1:0]  value;
  logic [pstsum_pkg::POS_W-1:0]  left_bound;
  logic [pstsum_pkg::POS_W-1:0]  right_bound;
  logic [pstsum_pkg::VER_W-1:0]  version;
} tree_item_t;

typedef struct {
  logic [pstsum_pkg::VAL_W-1:0]  sum;
  logic [pstsum_pkg::VER_W-1:0]  new_version;
  logic [pstsum_pkg::STAT_W-1:0] status;
} tree_result_t;

class tree_scoreboard;
  localparam int LEAVES   = 1024;
  localparam int VERSIONS = 1024;
  localparam int POOL     = 16384;

  logic [13:0]  kid_lo [POOL];
  logic [13:0]  kid_hi [POOL];
  logic [31:0]  node_total [POOL];
  logic [13:0]  version_root [VERSIONS];
  logic [31:0]  staged [LEAVES];
  int           versions_made;
  int           pool_used;
  int           leaves_built;
  logic [pstsum_pkg::CFG_W-1:0] leaf_reg;
  tree_result_t expected_results [$];
  int           errors;
  int           results_seen;

  function new();
    foreach (staged[i]) staged[i] = '0;
    versions_made = 0;
    pool_used = 0;
    leaves_built = 0;
    leaf_reg = pstsum_pkg::SIZE_RESET;
    errors = 0;
    results_seen = 0;
  endfunction

  function int leaves_now();
    if (leaf_reg < 1) return 1;
    if (leaf_reg > LEAVES) return LEAVES;
    return leaf_reg;
  endfunction

  function int grow(int lo, int hi);
    int me;
    int mid;
    int a;
    int b;
    me = pool_used;
    pool_used++;
    if (lo == hi) begin
      node_total[me] = staged[lo - 1];
      kid_lo[me] = '0;
      kid_hi[me] = '0;
      return me;
    end
    mid = (lo + hi) / 2;
    a = grow(lo, mid);
    b = grow(mid + 1, hi);
    kid_lo[me] = 14'(a);
    kid_hi[me] = 14'(b);
    node_total[me] = node_total[a] + node_total[b];
    return me;
  endfunction

  function int path_len(int n, int pos);
    int lo;
    int hi;
    int mid;
    int cnt;
    lo = 1;
    hi = n;
    cnt = 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (pos <= mid) hi = mid;
      else lo = mid + 1;
      cnt++;
    end
    return cnt;
  endfunction

  function int copy_path(int old, int lo, int hi, int pos, logic [31:0] add);
    int me;
    int mid;
    me = pool_used;
    pool_used++;
    if (lo == hi) begin
      node_total[me] = node_total[old] + add;
      kid_lo[me] = '0;
      kid_hi[me] = '0;
      return me;
    end
    mid = (lo + hi) / 2;
    if (pos <= mid) begin
      kid_hi[me] = kid_hi[old];
      kid_lo[me] = 14'(copy_path(kid_lo[old], lo, mid, pos, add));
    end else begin
      kid_lo[me] = kid_lo[old];
      kid_hi[me] = 14'(copy_path(kid_hi[old], mid + 1, hi, pos, add));
    end
    node_total[me] = node_total[kid_lo[me]] + node_total[kid_hi[me]];
    return me;
  endfunction

  function logic [31:0] span_total(int node, int lo, int hi, int ql, int qr);
    int mid;
    if (hi < ql || qr < lo) return '0;
    if (ql <= lo && hi <= qr) return node_total[node];
    mid = (lo + hi) / 2;
    return span_total(kid_lo[node], lo, mid, ql, qr) +
           span_total(kid_hi[node], mid + 1, hi, ql, qr);
  endfunction

  // Advance the tree model by one accepted item and queue its result.
  function void note_item(tree_item_t it);
    tree_result_t r;
    int pos;
    int ql;
    int qr;
    int n;
    pos = it.position;
    ql = it.left_bound;
    qr = it.right_bound;
    r.sum = '0;
    r.status = pstsum_pkg::ST_OK;
    case (it.action)
      pstsum_pkg::ACT_LOAD: begin
        if (pos < 1 || pos > leaves_now()) r.status = pstsum_pkg::ST_POSITION;
        else staged[pos - 1] = it.value;
      end
      pstsum_pkg::ACT_BUILD: begin
        n = leaves_now();
        if (2 * n - 1 > POOL) begin
          r.status = pstsum_pkg::ST_FULL;
        end else begin
          pool_used = 0;
          leaves_built = n;
          version_root[0] = 14'(grow(1, n));
          versions_made = 1;
        end
      end
      pstsum_pkg::ACT_UPDATE: begin
        if (versions_made == 0) r.status = pstsum_pkg::ST_VERSION;
        else if (pos < 1 || pos > leaves_built) r.status = pstsum_pkg::ST_POSITION;
        else if (versions_made >= VERSIONS ||
                 pool_used + path_len(leaves_built, pos) > POOL) begin
          r.status = pstsum_pkg::ST_FULL;
        end else begin
          version_root[versions_made] = 14'(copy_path(
            version_root[versions_made - 1], 1, leaves_built, pos, it.value));
          versions_made++;
        end
      end
      default: begin
        if (it.version >= versions_made) r.status = pstsum_pkg::ST_VERSION;
        else if (ql < 1 || ql > leaves_built || qr < 1 || qr > leaves_built)
          r.status = pstsum_pkg::ST_POSITION;
        else if (ql <= qr)
          r.sum = span_total(version_root[it.version], 1, leaves_built, ql, qr);
      end
    endcase
    r.new_version = pstsum_pkg::VER_W'((versions_made > 0) ? versions_made - 1 : 0);
    expected_results = {expected_results, r};
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task check_result(logic [31:0] s, logic [pstsum_pkg::VER_W-1:0] nv,
                    logic [pstsum_pkg::STAT_W-1:0] st);
    tree_result_t e;
    results_seen++;
    if (expected_results.size() == 0) begin
      report("result with no item outstanding");
      return;
    end
    e = expected_results.pop_front();
    if (s !== e.sum)
      report($sformatf("sum %h, expected %h", s, e.sum));
    if (nv !== e.new_version)
      report($sformatf("new_version %0d, expected %0d", nv, e.new_version));
    if (st !== e.status)
      report($sformatf("status %0d, expected %0d", st, e.status));
  endtask
endclass

module testbench;
  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic [pstsum_pkg::ACT_W-1:0]        action;
  logic [pstsum_pkg::POS_W-1:0]        position;
  logic signed [pstsum_pkg::VAL_W-1:0] value;
  logic [pstsum_pkg::POS_W-1:0]        left_bound;
  logic [pstsum_pkg::POS_W-1:0]        right_bound;
  logic [pstsum_pkg::VER_W-1:0]        version;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [pstsum_pkg::VAL_W-1:0] sum;
  logic [pstsum_pkg::VER_W-1:0]        new_version;
  logic [pstsum_pkg::STAT_W-1:0]       status;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [pstsum_pkg::CFG_W-1:0]        cfg_data;

  tree_scoreboard sb = new();
  int item_count = 0;
  bit long_hold_done = 0;

  persistent_segment_tree_sum_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .value(value),
    .left_bound(left_bound), .right_bound(right_bound), .version(version),
    .out_valid(out_valid), .out_stall(out_stall),
    .sum(sum), .new_version(new_version), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

  function int idle_len();
    int r;
    if (item_count % 200 < 30) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(sum, new_version, status);
  end

  // Receiver: random stalls, plus one long hold so the block backs up.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (!long_hold_done && sb.results_seen > 300) begin
        long_hold_done = 1;
        n = 400;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send(tree_item_t it);
    int n;
    action <= it.action;
    position <= it.position;
    value <= it.value;
    left_bound <= it.left_bound;
    right_bound <= it.right_bound;
    version <= it.version;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    item_count++;
    @(negedge clk);
    n = idle_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_leaf_count(logic [pstsum_pkg::CFG_W-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.leaf_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function tree_item_t mk(logic [pstsum_pkg::ACT_W-1:0] a, int p, logic [31:0] v,
                          int l, int r, int ver);
    tree_item_t it;
    it.action = a;
    it.position = pstsum_pkg::POS_W'(p);
    it.value = v;
    it.left_bound = pstsum_pkg::POS_W'(l);
    it.right_bound = pstsum_pkg::POS_W'(r);
    it.version = pstsum_pkg::VER_W'(ver);
    return it;
  endfunction

  function logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function int pick_pos(int n);
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, n);
    return $urandom_range(0, 2047);
  endfunction

  // Mostly well-formed items against the current tree; build_pct sets rebuilds.
  function tree_item_t pick_item(int build_pct, int update_pct);
    tree_item_t it;
    int r;
    int t;
    t = (sb.leaves_built > 0) ? sb.leaves_built : 1;
    it = mk(pstsum_pkg::ACT_QUERY, $urandom_range(0, 2047), pick_value(),
            $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < build_pct) begin
      it.action = pstsum_pkg::ACT_BUILD;
    end else if (r < build_pct + 12) begin
      it.action = pstsum_pkg::ACT_LOAD;
      it.position = pstsum_pkg::POS_W'(pick_pos(sb.leaves_now()));
    end else if (r < build_pct + 12 + update_pct) begin
      it.action = pstsum_pkg::ACT_UPDATE;
      it.position = pstsum_pkg::POS_W'(pick_pos(t));
    end else begin
      if (sb.versions_made > 0 && $urandom_range(0, 99) < 88)
        it.version = pstsum_pkg::VER_W'($urandom_range(0, sb.versions_made - 1));
      if ($urandom_range(0, 99) < 90) begin
        it.left_bound = pstsum_pkg::POS_W'($urandom_range(1, t));
        it.right_bound = ($urandom_range(0, 3) == 0)
                         ? pstsum_pkg::POS_W'($urandom_range(1, t))
                         : pstsum_pkg::POS_W'($urandom_range(it.left_bound, t));
      end
    end
    return it;
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = pstsum_pkg::ACT_LOAD;
    position = '0;
    value = '0;
    left_bound = '0;
    right_bound = '0;
    version = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Operations before any build, then bounds and value extremes.
    write_leaf_count(11'd2047);
    send(mk(pstsum_pkg::ACT_QUERY, 1, 0, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_UPDATE, 1, 5, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_LOAD, 1, 32'h7fff_ffff, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_LOAD, 1024, 32'h8000_0000, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_LOAD, 0, 7, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_LOAD, 1025, 7, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_LOAD, 2047, 7, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_LOAD, 512, 32'hffff_ffff, 1, 1, 0));
    send(mk(pstsum_pkg::ACT_BUILD, 0, 0, 0, 0, 0));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 1, 1024, 0));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 1024, 1, 0));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 0, 5, 0));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 3, 1025, 0));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 1, 1, 1023));
    send(mk(pstsum_pkg::ACT_UPDATE, 1, 32'h8000_0000, 0, 0, 0));
    send(mk(pstsum_pkg::ACT_UPDATE, 1024, 32'h7fff_ffff, 0, 0, 0));
    send(mk(pstsum_pkg::ACT_UPDATE, 0, 1, 0, 0, 0));
    send(mk(pstsum_pkg::ACT_UPDATE, 2047, 1, 0, 0, 0));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 1, 1024, 2));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 1024, 1024, 1));
    send(mk(pstsum_pkg::ACT_QUERY, 0, 0, 500, 600, 3));
    repeat (100) send(pick_item(3, 40));

    // Register of zero means one leaf.
    write_leaf_count(11'd0);
    send(mk(pstsum_pkg::ACT_LOAD, 1, 32'h1234_5678, 0, 0, 0));
    send(mk(pstsum_pkg::ACT_LOAD, 2, 1, 0, 0, 0));
    send(mk(pstsum_pkg::ACT_BUILD, 0, 0, 0, 0, 0));
    repeat (50) send(pick_item(3, 40));

    // Small tree, updates until the version table fills.
    write_leaf_count(11'd8);
    repeat (8) send(mk(pstsum_pkg::ACT_LOAD, $urandom_range(1, 8), pick_value(), 0, 0, 0));
    send(mk(pstsum_pkg::ACT_BUILD, 0, 0, 0, 0, 0));
    repeat (1030) send(mk(pstsum_pkg::ACT_UPDATE, $urandom_range(1, 8), pick_value(),
                          0, 0, 0));
    repeat (120) send(pick_item(0, 40));

    write_leaf_count(11'd1024);
    send(mk(pstsum_pkg::ACT_BUILD, 0, 0, 0, 0, 0));
    repeat (60) send(pick_item(2, 40));
    drain();
    repeat (40) send(pick_item(0, 40));

    drain();
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
